// File: rtl/u8sd_pkg.sv
package u8sd_pkg;

    // Width of the script mask and the positions of the shared bits.
    localparam int SCRIPT_COUNT = 21;
    localparam int BIT_CJK      = SCRIPT_COUNT - 2;
    localparam int BIT_GENERIC  = SCRIPT_COUNT - 1;

    localparam int CP_W      = 21;
    localparam int BIT_IDX_W = $clog2(SCRIPT_COUNT);

    localparam logic [CP_W-1:0] CP_REPLACEMENT = 21'h00FFFD;
    localparam logic [CP_W-1:0] CP_MAX         = 21'h10FFFF;
    localparam logic [CP_W-1:0] CP_ASCII_END   = 21'h000080;
    localparam logic [CP_W-1:0] CP_MIN_2BYTE   = 21'h000080;
    localparam logic [CP_W-1:0] CP_MIN_3BYTE   = 21'h000800;
    localparam logic [CP_W-1:0] CP_MIN_4BYTE   = 21'h010000;

    // Sequence length codes (length of the sequence minus one).
    localparam logic [1:0] SEQ_NONE = 2'd0;
    localparam logic [1:0] SEQ_TWO  = 2'd1;
    localparam logic [1:0] SEQ_THREE = 2'd2;
    localparam logic [1:0] SEQ_FOUR = 2'd3;

    typedef struct packed {
        logic [CP_W-1:0]      lo;
        logic [CP_W-1:0]      hi;
        logic [BIT_IDX_W-1:0] bit_idx;
    } t_range;

    localparam int RANGE_COUNT = 55;

    localparam logic [BIT_IDX_W-1:0] B_CJK = BIT_IDX_W'(BIT_CJK);

    // Ordered by priority: the lowest index that matches wins.
    localparam t_range SCRIPT_RANGES [RANGE_COUNT] = '{
        '{21'h00600, 21'h006FF, 5'd0},  '{21'h00750, 21'h0077F, 5'd0},
        '{21'h008A0, 21'h008FF, 5'd0},  '{21'h0FB50, 21'h0FDFF, 5'd0},
        '{21'h0FE70, 21'h0FEFF, 5'd0},  '{21'h1EE00, 21'h1EEFF, 5'd0},
        '{21'h00590, 21'h005FF, 5'd1},  '{21'h0FB1D, 21'h0FB4F, 5'd1},
        '{21'h00900, 21'h0097F, 5'd2},  '{21'h0A8E0, 21'h0A8FF, 5'd2},
        '{21'h00980, 21'h009FF, 5'd3},
        '{21'h00A00, 21'h00A7F, 5'd4},
        '{21'h00A80, 21'h00AFF, 5'd5},
        '{21'h00B00, 21'h00B7F, 5'd6},
        '{21'h00B80, 21'h00BFF, 5'd7},
        '{21'h00C00, 21'h00C7F, 5'd8},
        '{21'h00C80, 21'h00CFF, 5'd9},
        '{21'h00D00, 21'h00D7F, 5'd10},
        '{21'h00D80, 21'h00DFF, 5'd11},
        '{21'h00E00, 21'h00E7F, 5'd12},
        '{21'h00E80, 21'h00EFF, 5'd13},
        '{21'h01000, 21'h0109F, 5'd14}, '{21'h0A9E0, 21'h0A9FF, 5'd14},
        '{21'h0AA60, 21'h0AA7F, 5'd14},
        '{21'h01780, 21'h017FF, 5'd15}, '{21'h019E0, 21'h019FF, 5'd15},
        '{21'h00530, 21'h0058F, 5'd16}, '{21'h0FB13, 21'h0FB17, 5'd16},
        '{21'h010A0, 21'h010FF, 5'd17}, '{21'h02D00, 21'h02D2F, 5'd17},
        '{21'h01C90, 21'h01CBF, 5'd17},
        '{21'h01200, 21'h0137F, 5'd18}, '{21'h01380, 21'h0139F, 5'd18},
        '{21'h02D80, 21'h02DDF, 5'd18}, '{21'h0AB01, 21'h0AB2E, 5'd18},
        '{21'h03040, 21'h0309F, B_CJK}, '{21'h030A0, 21'h030FF, B_CJK},
        '{21'h031F0, 21'h031FF, B_CJK}, '{21'h0FF66, 21'h0FF9D, B_CJK},
        '{21'h01100, 21'h011FF, B_CJK}, '{21'h03130, 21'h0318F, B_CJK},
        '{21'h0A960, 21'h0A97F, B_CJK}, '{21'h0AC00, 21'h0D7AF, B_CJK},
        '{21'h0D7B0, 21'h0D7FF, B_CJK},
        '{21'h03100, 21'h0312F, B_CJK}, '{21'h031A0, 21'h031BF, B_CJK},
        '{21'h03400, 21'h04DBF, B_CJK}, '{21'h04E00, 21'h09FFF, B_CJK},
        '{21'h0F900, 21'h0FAFF, B_CJK}, '{21'h20000, 21'h2A6DF, B_CJK},
        '{21'h2A700, 21'h2B73F, B_CJK}, '{21'h2B740, 21'h2B81F, B_CJK},
        '{21'h2B820, 21'h2CEAF, B_CJK}, '{21'h2CEB0, 21'h2EBEF, B_CJK},
        '{21'h30000, 21'h3134F, B_CJK}
    };

    // One-hot mask bit for a decoded code point; zero for ASCII.
    function automatic logic [SCRIPT_COUNT-1:0] classify_cp(input logic [CP_W-1:0] cp);
        logic [SCRIPT_COUNT-1:0] mask;
        logic [BIT_IDX_W-1:0]    idx;
        idx  = BIT_IDX_W'(BIT_GENERIC);
        mask = '0;
        // Walk from the back so that the earliest match has the final word.
        for (int i = RANGE_COUNT - 1; i >= 0; i--) begin
            if (cp >= SCRIPT_RANGES[i].lo && cp <= SCRIPT_RANGES[i].hi) begin
                idx = SCRIPT_RANGES[i].bit_idx;
            end
        end
        if (cp >= CP_ASCII_END) begin
            mask[idx] = 1'b1;
        end
        return mask;
    endfunction

endpackage

// File: rtl/utf8_script_detector_core.sv
// A byte is registered on acceptance; the mask of a name is written into the
// output register when its last byte leaves the input register.
// Throughput: one byte per cycle, limited only by the output register being taken.
// Reset: i_rst_n is synchronous and active low; it empties both registers and
// clears the decoder state and the gathered mask.
module utf8_script_detector_core
    import u8sd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // end_of_name
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [20:0] script_mask, [23:21] zero
);

    // The design is a two-register pipeline. The input register holds one
    // accepted byte. When the byte moves on, the decoder folds it into the running
    // UTF-8 state and the gathered script mask. When the byte closes a name,
    // the final mask is written into the output register and the state is
    // cleared, so that the first byte of the next name sees a fresh decoder.

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    logic [1:0]              r_pending;
    logic [1:0]              r_seq_len;
    logic [CP_W-1:0]         r_partial;
    logic [SCRIPT_COUNT-1:0] r_seen;
    logic                    r_term;

    logic                    r_out_valid;
    logic [SCRIPT_COUNT-1:0] r_out_mask;

    logic [1:0]              n_pending;
    logic [1:0]              n_seq_len;
    logic [CP_W-1:0]         n_partial;
    logic                    n_term;
    logic [SCRIPT_COUNT-1:0] n_seen;

    logic                    process_en;
    logic                    is_cont;
    logic [CP_W-1:0]         cp_shifted;
    logic [CP_W-1:0]         cp_min;
    logic [CP_W-1:0]         cp_final;
    logic [SCRIPT_COUNT-1:0] generic_bit;

    // A byte that does not end a name never needs the output register, so it
    // always moves on. A closing byte waits until the output register is free
    // or is being emptied in this same cycle.
    assign process_en    = r_in_valid && (!r_in_last || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || process_en;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(24 - SCRIPT_COUNT){1'b0}}, r_out_mask};

    assign generic_bit = SCRIPT_COUNT'(1) << BIT_GENERIC;

    // A continuation byte only counts as such while a sequence is open.
    assign is_cont    = (r_pending != 2'd0) && (r_in_byte[7:6] == 2'b10);
    assign cp_shifted = {r_partial[CP_W-7:0], r_in_byte[5:0]};

    // Overlong forms and values beyond the Unicode range become U+FFFD.
    always_comb begin
        unique case (r_seq_len)
            SEQ_TWO:   cp_min = CP_MIN_2BYTE;
            SEQ_THREE: cp_min = CP_MIN_3BYTE;
            default:   cp_min = CP_MIN_4BYTE;
        endcase
        if (cp_shifted < cp_min || cp_shifted > CP_MAX) begin
            cp_final = CP_REPLACEMENT;
        end else begin
            cp_final = cp_shifted;
        end
    end

    always_comb begin
        n_pending = r_pending;
        n_seq_len = r_seq_len;
        n_partial = r_partial;
        n_term    = r_term;
        n_seen    = r_seen;
        if (!r_term) begin
            if (is_cont) begin
                n_partial = cp_shifted;
                n_pending = r_pending - 2'd1;
                if (r_pending == 2'd1) begin
                    n_seen = r_seen | classify_cp(cp_final);
                end
            end else begin
                // A broken sequence marks the fallback bit, and the same byte
                // is then decoded again as the start of a new character.
                if (r_pending != 2'd0) begin
                    n_seen    = n_seen | generic_bit;
                    n_pending = 2'd0;
                    n_seq_len = SEQ_NONE;
                    n_partial = '0;
                end
                if (r_in_byte == 8'h00) begin
                    n_term = 1'b1;
                end else if (r_in_byte[7] == 1'b0) begin
                    // ASCII characters do not touch the mask.
                end else if (r_in_byte[7:5] == 3'b110) begin
                    n_partial = CP_W'(r_in_byte[4:0]);
                    n_pending = 2'd1;
                    n_seq_len = SEQ_TWO;
                end else if (r_in_byte[7:4] == 4'b1110) begin
                    n_partial = CP_W'(r_in_byte[3:0]);
                    n_pending = 2'd2;
                    n_seq_len = SEQ_THREE;
                end else if (r_in_byte[7:3] == 5'b11110) begin
                    n_partial = CP_W'(r_in_byte[2:0]);
                    n_pending = 2'd3;
                    n_seq_len = SEQ_FOUR;
                end else begin
                    // Stray continuation bytes and impossible lead bytes.
                    n_seen = n_seen | generic_bit;
                end
            end
        end
        // A name that ends inside an open sequence counts as a bad character.
        if (r_in_last && n_pending != 2'd0 && !n_term) begin
            n_seen = n_seen | generic_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 2'd0;
            r_seq_len <= SEQ_NONE;
            r_partial <= '0;
            r_seen    <= '0;
            r_term    <= 1'b0;
        end else if (process_en) begin
            if (r_in_last) begin
                r_pending <= 2'd0;
                r_seq_len <= SEQ_NONE;
                r_partial <= '0;
                r_seen    <= '0;
                r_term    <= 1'b0;
            end else begin
                r_pending <= n_pending;
                r_seq_len <= n_seq_len;
                r_partial <= n_partial;
                r_seen    <= n_seen;
                r_term    <= n_term;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (process_en && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (process_en && r_in_last) begin
            r_out_mask <= n_seen;
        end
    end

endmodule
